### rtl/core/tpbt_pkg.sv
package tpbt_pkg;

  // One input word: a poll tick or the completion of a burst read.
  typedef struct packed {
    logic       req_type;
    logic [31:0] now_ms;
    logic       irq_active;
    logic       read_ok;
    logic [7:0] gesture_code;
    logic [7:0] finger_count;
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic        start_read;
    logic        reset_pulse;
    logic        report_taken;
    logic        touch_down;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic        swipe_valid;
    logic [1:0]  swipe_dir;
  } out_word_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RELEASE_TIMEOUT = 3'd0,
    CFG_RELEASE_POLLS   = 3'd1,
    CFG_POLL_INTERVAL   = 3'd2,
    CFG_BACKOFF_MAX     = 3'd3,
    CFG_QUIET_FAILS     = 3'd4,
    CFG_RECOVER_AFTER   = 3'd5,
    CFG_RECOVER_COOL    = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] RstReleaseTimeout = 16'd60;
  localparam logic [15:0] RstReleasePolls   = 16'd8;
  localparam logic [9:0]  RstPollInterval   = 10'd10;
  localparam logic [15:0] RstBackoffMax     = 16'd160;
  localparam logic [2:0]  RstQuietFails     = 3'd4;
  localparam logic [15:0] RstRecoverAfter   = 16'd2000;
  localparam logic [15:0] RstRecoverCool    = 16'd1000;

  localparam logic [7:0] GestNone  = 8'd0;
  localparam logic [7:0] GestDown  = 8'd1;
  localparam logic [7:0] GestUp    = 8'd2;
  localparam logic [7:0] GestLeft  = 8'd3;
  localparam logic [7:0] GestRight = 8'd4;

  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  localparam logic [15:0] IdleMax = 16'hFFFF;

endpackage

### rtl/core/touch_poll_backoff_tracker_unit.sv
// Each result word is registered in the output register; one word is taken per cycle unless
// a stalled result holds it. The whole tick or completion decision is a single pass
// of compares and a shift between the scheduler state registers and the output register.
// Reset (rst_ni low, asynchronous) clears all scheduler state, empties the output register
// and loads the configuration registers with their default values.
module touch_poll_backoff_tracker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tpbt_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tpbt_pkg::out_word_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpbt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tpbt_pkg::CfgDataW-1:0] cfg_data_i
);
  import tpbt_pkg::*;

  // Configuration registers. Writes are always taken; an index beyond the list is ignored.
  logic [15:0] rel_timeout_q, rel_polls_q, backoff_max_q, recover_after_q, recover_cool_q;
  logic [9:0]  poll_interval_q;
  logic [2:0]  quiet_fails_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_timeout_q   <= RstReleaseTimeout;
      rel_polls_q     <= RstReleasePolls;
      poll_interval_q <= RstPollInterval;
      backoff_max_q   <= RstBackoffMax;
      quiet_fails_q   <= RstQuietFails;
      recover_after_q <= RstRecoverAfter;
      recover_cool_q  <= RstRecoverCool;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RELEASE_TIMEOUT: rel_timeout_q   <= cfg_data_i;
        CFG_RELEASE_POLLS:   rel_polls_q     <= cfg_data_i;
        CFG_POLL_INTERVAL:   poll_interval_q <= cfg_data_i[9:0];
        CFG_BACKOFF_MAX:     backoff_max_q   <= cfg_data_i;
        CFG_QUIET_FAILS:     quiet_fails_q   <= cfg_data_i[2:0];
        CFG_RECOVER_AFTER:   recover_after_q <= cfg_data_i;
        CFG_RECOVER_COOL:    recover_cool_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake. The output register is refilled in the same cycle that its word leaves,
  // so a new word is taken every cycle unless a finished word is held up downstream.
  logic out_valid_q;
  logic in_acc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Scheduler state.
  logic        touch_q, prev_active_q, tick_int_q, silence_valid_q;
  logic [7:0]  gesture_q;
  logic [31:0] last_report_q, last_attempt_q, silence_start_q, last_reset_q, tick_time_q;
  logic [15:0] idle_q;
  logic [2:0]  unans_q;
  logic [11:0] x_q, y_q;

  logic        touch_d, prev_active_d, tick_int_d, silence_valid_d;
  logic [7:0]  gesture_d;
  logic [31:0] last_report_d, last_attempt_d, silence_start_d, last_reset_d, tick_time_d;
  logic [15:0] idle_d;
  logic [2:0]  unans_d;
  logic [11:0] x_d, y_d;
  out_word_t   res_d, out_data_q;

  // Shared decision terms.
  logic [16:0] iv_raw;
  logic [15:0] interval;
  logic        quiet, wait_more, release_now, fire_pulse, issue_read;
  logic [31:0] idle_time, sil_start_eff;
  logic [15:0] idle_inc;

  always_comb begin
    // Backoff interval: base period doubled per unanswered read, capped at the ceiling.
    iv_raw   = 17'(poll_interval_q) << unans_q;
    interval = (iv_raw > {1'b0, backoff_max_q}) ? backoff_max_q : iv_raw[15:0];
    quiet    = unans_q >= quiet_fails_q;
    wait_more = (in_data_i.now_ms - last_attempt_q) < {16'd0, interval};
    issue_read = in_data_i.irq_active || !(quiet || wait_more);

    // Idle counting is shared by an idle tick and a failed read; a failed read takes its
    // time from the tick that requested it.
    idle_time   = in_data_i.req_type ? tick_time_q : in_data_i.now_ms;
    idle_inc    = (idle_q != IdleMax) ? idle_q + 16'd1 : idle_q;
    release_now = touch_q && (idle_inc >= rel_polls_q) &&
                  ((idle_time - last_report_q) >= {16'd0, rel_timeout_q});

    // Recovery pulse: silence measured from the first failure after the last report.
    sil_start_eff = silence_valid_q ? silence_start_q : tick_time_q;
    fire_pulse    = tick_int_q &&
                    ((tick_time_q - sil_start_eff) > {16'd0, recover_after_q}) &&
                    ((tick_time_q - last_reset_q) > {16'd0, recover_cool_q});

    touch_d         = touch_q;
    prev_active_d   = prev_active_q;
    tick_int_d      = tick_int_q;
    silence_valid_d = silence_valid_q;
    gesture_d       = gesture_q;
    last_report_d   = last_report_q;
    last_attempt_d  = last_attempt_q;
    silence_start_d = silence_start_q;
    last_reset_d    = last_reset_q;
    tick_time_d     = tick_time_q;
    idle_d          = idle_q;
    unans_d         = unans_q;
    x_d             = x_q;
    y_d             = y_q;

    res_d              = '0;

    if (!in_data_i.req_type) begin
      if (issue_read) begin
        last_attempt_d   = in_data_i.now_ms;
        tick_time_d      = in_data_i.now_ms;
        tick_int_d       = in_data_i.irq_active;
        res_d.start_read = 1'b1;
      end else begin
        idle_d = idle_inc;
        if (release_now) begin
          touch_d       = 1'b0;
          prev_active_d = 1'b0;
        end
      end
    end else if (!in_data_i.read_ok) begin
      if (unans_q < quiet_fails_q) begin
        unans_d = unans_q + 3'd1;
      end
      silence_valid_d = 1'b1;
      silence_start_d = sil_start_eff;
      if (fire_pulse) begin
        last_reset_d      = tick_time_q;
        res_d.reset_pulse = 1'b1;
      end
      idle_d = idle_inc;
      if (release_now) begin
        touch_d       = 1'b0;
        prev_active_d = 1'b0;
      end
    end else begin
      unans_d         = 3'd0;
      silence_valid_d = 1'b0;
      silence_start_d = 32'd0;
      idle_d          = 16'd0;
      last_report_d   = tick_time_q;
      touch_d         = in_data_i.finger_count != 8'd0;
      if (touch_d) begin
        x_d = {in_data_i.x_high[3:0], in_data_i.x_low};
        y_d = {in_data_i.y_high[3:0], in_data_i.y_low};
        if (!prev_active_q) begin
          gesture_d = GestNone;
        end
      end
      if (in_data_i.gesture_code != GestNone) begin
        gesture_d = in_data_i.gesture_code;
      end
      prev_active_d      = touch_d;
      res_d.report_taken = 1'b1;
    end

    res_d.touch_down = touch_d;
    res_d.x_pos      = x_d;
    res_d.y_pos      = y_d;

    // Swipe direction as seen by the user: each gesture code maps to the direction of its name.
    unique case (gesture_d)
      GestDown:  begin res_d.swipe_valid = 1'b1; res_d.swipe_dir = DirDown;  end
      GestUp:    begin res_d.swipe_valid = 1'b1; res_d.swipe_dir = DirUp;    end
      GestLeft:  begin res_d.swipe_valid = 1'b1; res_d.swipe_dir = DirLeft;  end
      GestRight: begin res_d.swipe_valid = 1'b1; res_d.swipe_dir = DirRight; end
      default:   begin res_d.swipe_valid = 1'b0; res_d.swipe_dir = DirUp;    end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_q         <= 1'b0;
      prev_active_q   <= 1'b0;
      tick_int_q      <= 1'b0;
      silence_valid_q <= 1'b0;
      gesture_q       <= GestNone;
      last_report_q   <= 32'd0;
      last_attempt_q  <= 32'd0;
      silence_start_q <= 32'd0;
      last_reset_q    <= 32'd0;
      tick_time_q     <= 32'd0;
      idle_q          <= 16'd0;
      unans_q         <= 3'd0;
      x_q             <= 12'd0;
      y_q             <= 12'd0;
    end else if (in_acc) begin
      touch_q         <= touch_d;
      prev_active_q   <= prev_active_d;
      tick_int_q      <= tick_int_d;
      silence_valid_q <= silence_valid_d;
      gesture_q       <= gesture_d;
      last_report_q   <= last_report_d;
      last_attempt_q  <= last_attempt_d;
      silence_start_q <= silence_start_d;
      last_reset_q    <= last_reset_d;
      tick_time_q     <= tick_time_d;
      idle_q          <= idle_d;
      unans_q         <= unans_d;
      x_q             <= x_d;
      y_q             <= y_d;
    end
  end

  // Output register: loaded on every accepted word, emptied when its word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= res_d;
    end
  end

  assign out_data_o = out_data_q;

`ifndef SYNTHESIS
  // A word is either a tick result or a completion result, never both.
  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.start_read && (out_data_o.reset_pulse ||
                      out_data_o.report_taken)))
    else $error("tick and completion flags set in one result word");

  // A decoded report clears the failure and idle history.
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.req_type && in_data_i.read_ok) |=>
      (unans_q == 3'd0 && idle_q == 16'd0 && !silence_valid_q))
    else $error("report did not clear failure history");

  // Every accepted word leaves a result in the output register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted word produced no result");

  // Direction is zero whenever no swipe is latched.
  a_dir_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.swipe_valid) |-> (out_data_o.swipe_dir == DirUp))
    else $error("swipe direction set without a swipe");

  // The failure count never passes the quiet threshold by counting.
  a_unans_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.req_type && !in_data_i.read_ok &&
     unans_q >= quiet_fails_q) |=> $stable(unans_q))
    else $error("unanswered count grew while quiet");
`endif

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tpbt_pkg::*;

  // The run is ended by force after this many clock cycles.
  localparam int unsigned CycleLimit = 100000;
  // Share of cycles, in percent, in which either side idles when it is allowed to.
  localparam int unsigned IdlePct    = 36;
  localparam int unsigned MaxReports = 10;
  // The unit registers its answer in the cycle after a word is taken.
  localparam int unsigned DrainCycles = 3;

  // One complete set of the seven scheduler registers.
  typedef struct packed {
    logic [15:0] release_timeout;
    logic [15:0] release_polls;
    logic [9:0]  poll_interval;
    logic [15:0] backoff_max;
    logic [2:0]  quiet_fails;
    logic [15:0] recover_after;
    logic [15:0] recover_cool;
  } reg_set_t;

  localparam reg_set_t DefaultRegs = '{
    release_timeout: RstReleaseTimeout, release_polls: RstReleasePolls,
    poll_interval: RstPollInterval, backoff_max: RstBackoffMax,
    quiet_fails: RstQuietFails, recover_after: RstRecoverAfter,
    recover_cool: RstRecoverCool
  };

  // ---------------------------------------------------------------------------------------
  // Clock, reset and the signals around the unit. Every input starts at a known value.
  // ---------------------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  in_word_t            in_data   = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_data;
  logic                cfg_valid = 1'b0;
  cfg_idx_e            cfg_index = CFG_RELEASE_TIMEOUT;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                cfg_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_poll_backoff_tracker_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------------------
  // Scheduler predictor. It keeps its own copy of the registers and of the scheduler state
  // and is stepped once for every word the unit accepts, in acceptance order.
  // ---------------------------------------------------------------------------------------
  logic [15:0] reg_release_timeout = RstReleaseTimeout;
  logic [15:0] reg_release_polls   = RstReleasePolls;
  logic [9:0]  reg_poll_interval   = RstPollInterval;
  logic [15:0] reg_backoff_max     = RstBackoffMax;
  logic [2:0]  reg_quiet_fails     = RstQuietFails;
  logic [15:0] reg_recover_after   = RstRecoverAfter;
  logic [15:0] reg_recover_cool    = RstRecoverCool;

  logic        touch_held      = 1'b0;
  logic        was_touching    = 1'b0;
  logic [7:0]  swipe_code      = GestNone;
  logic [31:0] report_at_ms    = '0;
  logic [31:0] attempt_at_ms   = '0;
  logic [15:0] idle_ticks      = '0;
  logic [2:0]  misses          = '0;
  logic        silence_open    = 1'b0;
  logic [31:0] silence_from_ms = '0;
  logic [31:0] last_pulse_ms   = '0;
  logic [11:0] touch_x         = '0;
  logic [11:0] touch_y         = '0;
  logic [31:0] read_tick_ms    = '0;
  logic        read_tick_irq   = 1'b0;

  // Results predicted for accepted words and not yet seen at the output, oldest first.
  out_word_t awaited_status[$];

  // An idle poll: bump the saturating poll count and infer a release once the touch has
  // been silent long enough and enough polls went by. Time differences wrap at 2^32.
  function automatic void count_idle_poll(input logic [31:0] now);
    if (idle_ticks != IdleMax) idle_ticks = idle_ticks + 16'd1;
    if (touch_held && idle_ticks >= reg_release_polls &&
        (now - report_at_ms) >= {16'd0, reg_release_timeout}) begin
      touch_held   = 1'b0;
      was_touching = 1'b0;
    end
  endfunction

  function automatic out_word_t predict_poll_outcome(input in_word_t w);
    out_word_t   r;
    logic [31:0] now;
    logic [31:0] interval;
    logic        quiet;
    r = '0;
    if (w.req_type == 1'b0) begin
      // Poll tick: the interval doubles with every unanswered read, up to the ceiling.
      now      = w.now_ms;
      quiet    = misses >= reg_quiet_fails;
      interval = {22'd0, reg_poll_interval} << misses;
      if (interval > {16'd0, reg_backoff_max}) interval = {16'd0, reg_backoff_max};
      if (!w.irq_active && (quiet || (now - attempt_at_ms) < interval)) begin
        count_idle_poll(now);
      end else begin
        attempt_at_ms   = now;
        read_tick_ms    = now;
        read_tick_irq   = w.irq_active;
        r.start_read    = 1'b1;
      end
    end else if (!w.read_ok) begin
      // Unanswered read. Its time is the one stored by the tick that asked for it.
      now = read_tick_ms;
      if (misses < reg_quiet_fails) misses = misses + 3'd1;
      if (!silence_open) begin
        silence_open    = 1'b1;
        silence_from_ms = now;
      end
      if (read_tick_irq && (now - silence_from_ms) > {16'd0, reg_recover_after} &&
          (now - last_pulse_ms) > {16'd0, reg_recover_cool}) begin
        last_pulse_ms = now;
        r.reset_pulse = 1'b1;
      end
      count_idle_poll(now);
    end else begin
      // Answered read: decode the report. Coordinates only move while a finger is down,
      // and a fresh touch forgets the gesture of the previous one.
      misses          = '0;
      silence_open    = 1'b0;
      silence_from_ms = '0;
      idle_ticks      = '0;
      report_at_ms    = read_tick_ms;
      touch_held      = w.finger_count != 8'd0;
      if (touch_held) begin
        touch_x = {w.x_high[3:0], w.x_low};
        touch_y = {w.y_high[3:0], w.y_low};
        if (!was_touching) swipe_code = GestNone;
      end
      if (w.gesture_code != GestNone) swipe_code = w.gesture_code;
      was_touching   = touch_held;
      r.report_taken = 1'b1;
    end
    r.touch_down = touch_held;
    r.x_pos      = touch_x;
    r.y_pos      = touch_y;
    // The controller's vertical swipe codes map straight to the directions of the same name.
    case (swipe_code)
      GestDown: begin
        r.swipe_valid = 1'b1;
        r.swipe_dir   = DirDown;
      end
      GestUp: begin
        r.swipe_valid = 1'b1;
        r.swipe_dir   = DirUp;
      end
      GestLeft: begin
        r.swipe_valid = 1'b1;
        r.swipe_dir   = DirLeft;
      end
      GestRight: begin
        r.swipe_valid = 1'b1;
        r.swipe_dir   = DirRight;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Output side. The stall is driven at the rising edge; a long hold-off can be requested
  // by a test and is counted down here, one cycle at a time.
  // ---------------------------------------------------------------------------------------
  logic        steady_flow     = 1'b0;
  int unsigned rx_hold_request = 0;
  int unsigned rx_hold_left    = 0;

  always @(posedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(99) < IdlePct);
    end
  end

  // The outputs are sampled at the falling edge, where they have settled; a word counts as
  // taken at the next rising edge if it was valid and not stalled at that sample.
  logic        seen_valid = 1'b0;
  logic        seen_stall = 1'b0;
  out_word_t   seen_data  = '0;
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;

  always @(negedge clk) begin
    seen_valid = out_valid && rst_n;
    seen_stall = out_stall;
    seen_data  = out_data;
  end

  function automatic string describe(input out_word_t s);
    return $sformatf("start=%0b pulse=%0b taken=%0b touch=%0b x=%03h y=%03h swipe=%0b dir=%0d",
                     s.start_read, s.reset_pulse, s.report_taken, s.touch_down,
                     s.x_pos, s.y_pos, s.swipe_valid, s.swipe_dir);
  endfunction

  always @(posedge clk) begin : result_check
    out_word_t want;
    logic      bad;
    if (seen_valid && !seen_stall) begin
      result_count++;
      if (awaited_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("result word %0d arrived with nothing expected: %s",
                   result_count, describe(seen_data));
      end else begin
        want = awaited_status.pop_front();
        bad  = (seen_data.start_read   !== want.start_read)   ||
               (seen_data.reset_pulse  !== want.reset_pulse)  ||
               (seen_data.report_taken !== want.report_taken) ||
               (seen_data.touch_down   !== want.touch_down)   ||
               (seen_data.x_pos        !== want.x_pos)        ||
               (seen_data.y_pos        !== want.y_pos)        ||
               (seen_data.swipe_valid  !== want.swipe_valid)  ||
               (seen_data.swipe_dir    !== want.swipe_dir);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("result word %0d mismatch", result_count);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(seen_data));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("touch_poll_backoff_tracker_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input side. Every task below is entered and left just after a rising edge.
  // ---------------------------------------------------------------------------------------

  // Offer one word, idling first at random, and hold it steady until the unit takes it.
  // The predictor is stepped at the edge where the word is taken.
  task automatic offer_word(input in_word_t w, output out_word_t outcome);
    logic stalled;
    while (!steady_flow && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    outcome = predict_poll_outcome(w);
    awaited_status.push_back(outcome);
  endtask

  // Stop offering and wait until every predicted word has come out, then wait out the drain time.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    logic ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    case (idx)
      CFG_RELEASE_TIMEOUT: reg_release_timeout = value;
      CFG_RELEASE_POLLS:   reg_release_polls   = value;
      CFG_POLL_INTERVAL:   reg_poll_interval   = value[9:0];
      CFG_BACKOFF_MAX:     reg_backoff_max     = value;
      CFG_QUIET_FAILS:     reg_quiet_fails     = value[2:0];
      CFG_RECOVER_AFTER:   reg_recover_after   = value;
      CFG_RECOVER_COOL:    reg_recover_cool    = value;
      default: ;
    endcase
  endtask

  // Registers are only rewritten once the unit has nothing left in flight.
  task automatic set_regs(input reg_set_t s);
    settle();
    write_reg(CFG_RELEASE_TIMEOUT, s.release_timeout);
    write_reg(CFG_RELEASE_POLLS, s.release_polls);
    write_reg(CFG_POLL_INTERVAL, {6'd0, s.poll_interval});
    write_reg(CFG_BACKOFF_MAX, s.backoff_max);
    write_reg(CFG_QUIET_FAILS, {13'd0, s.quiet_fails});
    write_reg(CFG_RECOVER_AFTER, s.recover_after);
    write_reg(CFG_RECOVER_COOL, s.recover_cool);
    cfg_valid <= 1'b0;
  endtask

  // A poll tick. The report bytes and the read flag are ignored on a tick, so they carry
  // random noise.
  function automatic in_word_t tick_word(input logic [31:0] now, input logic irq);
    in_word_t w;
    w.req_type     = 1'b0;
    w.now_ms       = now;
    w.irq_active   = irq;
    w.read_ok      = $urandom_range(1) == 1;
    w.gesture_code = 8'($urandom);
    w.finger_count = 8'($urandom);
    w.x_high       = 8'($urandom);
    w.x_low        = 8'($urandom);
    w.y_high       = 8'($urandom);
    w.y_low        = 8'($urandom);
    return w;
  endfunction

  // A read completion. The time and interrupt fields are ignored, so they are random.
  function automatic in_word_t done_word(input logic ok,
                                         input logic [7:0] gest, fingers, xh, xl, yh, yl);
    in_word_t w;
    w.req_type     = 1'b1;
    w.now_ms       = $urandom;
    w.irq_active   = $urandom_range(1) == 1;
    w.read_ok      = ok;
    w.gesture_code = gest;
    w.finger_count = fingers;
    w.x_high       = xh;
    w.x_low        = xl;
    w.y_high       = yh;
    w.y_low        = yl;
    return w;
  endfunction

  // A completion with a plausible report: mostly no gesture, sometimes a swipe, now and
  // then any byte; a lifted finger in about a quarter of the reports.
  function automatic in_word_t report_word(input logic ok);
    logic [7:0]  gest;
    logic [7:0]  fingers;
    int unsigned pick;
    pick    = $urandom_range(99);
    gest    = pick < 55 ? GestNone : pick < 90 ? 8'($urandom_range(1, 4)) : 8'($urandom);
    pick    = $urandom_range(99);
    fingers = pick < 25 ? 8'd0 : pick < 80 ? 8'd1 : 8'($urandom);
    return done_word(ok, gest, fingers, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
  endfunction

  // Random traffic under one register setting. Most of it is well formed: a tick, and when
  // the tick asks for a read, usually its completion. The controller drifts between dead,
  // flaky and healthy so that backoff, quiet mode and recovery pulses are all reached.
  // Stray completions and jumps of the clock, also across the wrap, make up the noise.
  task automatic drive_traffic(input reg_set_t regs, input int unsigned n_items,
                               input int unsigned stride, input int unsigned hold);
    in_word_t    w;
    out_word_t   seen;
    logic [31:0] clock_ms;
    int unsigned sent;
    int unsigned roll;
    int unsigned ok_pct;
    set_regs(regs);
    rx_hold_request = hold;
    clock_ms = $urandom;
    ok_pct   = 70;
    sent     = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) < 3) begin
        case ($urandom_range(2))
          0:       ok_pct = 0;
          1:       ok_pct = 70;
          default: ok_pct = 95;
        endcase
      end
      if (roll < 8) begin
        w = report_word($urandom_range(1) == 1);
      end else begin
        if (roll < 13)      clock_ms = $urandom;
        else if (roll < 16) clock_ms = 32'hFFFF_FFFF - $urandom_range(4 * stride);
        else if (roll < 40) clock_ms = clock_ms + $urandom_range(8 * stride);
        else                clock_ms = clock_ms + $urandom_range(stride);
        w = tick_word(clock_ms, $urandom_range(99) < 25);
      end
      offer_word(w, seen);
      sent++;
      if (!w.req_type && seen.start_read && $urandom_range(9) != 0) begin
        offer_word(report_word($urandom_range(99) < ok_pct), seen);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Hand-made words at the reset settings: decoding of every gesture, coordinate extremes,
  // a lifted finger, the cadence, backoff into quiet mode, release inference, recovery
  // pulses with their cooldown, and time that wraps.
  task automatic test_directed_cases();
    out_word_t seen;
    // A completion before any tick works with the zero time held since reset. The upper
    // nibbles of the coordinate bytes must be dropped.
    offer_word(done_word(1'b1, GestDown, 8'd1, 8'hF3, 8'h21, 8'hAB, 8'hFF), seen);
    offer_word(tick_word(32'd0, 1'b0), seen);
    offer_word(tick_word(32'd10, 1'b0), seen);
    offer_word(done_word(1'b1, GestUp, 8'd255, 8'h00, 8'h00, 8'hF0, 8'h00), seen);
    // A report with no finger ends the touch but keeps the coordinates and the gesture.
    offer_word(done_word(1'b1, GestNone, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF), seen);
    // A new touch clears the latched gesture.
    offer_word(done_word(1'b1, GestNone, 8'd1, 8'h0F, 8'hFF, 8'h5F, 8'hFF), seen);
    offer_word(done_word(1'b1, GestLeft, 8'd2, 8'h01, 8'h80, 8'h02, 8'h40), seen);
    offer_word(done_word(1'b1, GestRight, 8'd3, 8'h03, 8'h00, 8'h04, 8'h00), seen);
    offer_word(done_word(1'b1, 8'd5, 8'd1, 8'h00, 8'h11, 8'h00, 8'h22), seen);
    offer_word(done_word(1'b1, 8'd255, 8'd128, 8'h07, 8'h77, 8'h08, 8'h88), seen);
    // Unanswered reads back off until the block goes quiet; idle polls then release.
    repeat (4) offer_word(report_word(1'b0), seen);
    repeat (4) offer_word(tick_word(32'd100, 1'b0), seen);
    // The interrupt still forces reads. After a long silence a reset pulse is asked for,
    // the next one is held back by the cooldown, and a wrapped time allows another.
    offer_word(tick_word(32'd2011, 1'b1), seen);
    offer_word(report_word(1'b0), seen);
    offer_word(tick_word(32'd2500, 1'b1), seen);
    offer_word(report_word(1'b0), seen);
    offer_word(tick_word(32'hFFFF_FFF0, 1'b1), seen);
    offer_word(report_word(1'b0), seen);
    offer_word(tick_word(32'hFFFF_FFFF, 1'b0), seen);
    offer_word(report_word(1'b1), seen);
    // The interval is measured across the wrap of the millisecond clock.
    offer_word(tick_word(32'd5, 1'b0), seen);
  endtask

  // A run of idle polls with no idling on either side. With one unanswered read the block
  // is quiet, so every plain tick is an idle poll; the touch stays down while the timeout
  // runs and is released by the last tick, once both the poll count and the timeout allow.
  task automatic test_idle_release();
    out_word_t   seen;
    int unsigned i;
    set_regs('{release_timeout: 16'hFFFF, release_polls: 16'd16, poll_interval: 10'd1023,
               backoff_max: 16'hFFFF, quiet_fails: 3'd1, recover_after: 16'hFFFF,
               recover_cool: 16'hFFFF});
    steady_flow = 1'b1;
    offer_word(tick_word(32'd1000, 1'b1), seen);
    offer_word(done_word(1'b1, GestNone, 8'd1, 8'h0A, 8'hBC, 8'h0D, 8'hEF), seen);
    offer_word(report_word(1'b0), seen);
    for (i = 0; i < 20; i++)
      offer_word(tick_word(32'd1000 + $urandom_range(500), 1'b0), seen);
    offer_word(tick_word(32'd1000 + 32'd65535, 1'b0), seen);
    steady_flow = 1'b0;
  endtask

  // The reset values written back explicitly, settings at or near both ends of every
  // register, and a quiet threshold of zero, which leaves only the interrupt to start reads.
  task automatic test_extreme_settings();
    reg_set_t quiet_zero;
    drive_traffic(DefaultRegs, 350, 15, 0);
    drive_traffic('{release_timeout: 16'd0, release_polls: 16'd0, poll_interval: 10'd1,
                    backoff_max: 16'd1, quiet_fails: 3'd1, recover_after: 16'd0,
                    recover_cool: 16'd0}, 300, 3, 0);
    drive_traffic('{release_timeout: 16'hFFFF, release_polls: 16'hFFFF,
                    poll_interval: 10'd1023, backoff_max: 16'hFFFF, quiet_fails: 3'd7,
                    recover_after: 16'hFFFF, recover_cool: 16'hFFFF}, 300, 3000, 0);
    quiet_zero             = DefaultRegs;
    quiet_zero.quiet_fails = 3'd0;
    drive_traffic(quiet_zero, 200, 20, 0);
  endtask

  // Random register settings in a range where release, backoff and recovery all happen
  // within a few hundred words. The middle phase runs with no idling on either side.
  task automatic test_random_settings();
    reg_set_t    regs;
    int unsigned phase;
    for (phase = 0; phase < 3; phase++) begin
      regs.release_timeout = 16'($urandom_range(200));
      regs.release_polls   = 16'($urandom_range(20));
      regs.poll_interval   = 10'($urandom_range(1, 60));
      regs.backoff_max     = 16'($urandom_range(1, 2000));
      regs.quiet_fails     = 3'($urandom_range(1, 7));
      regs.recover_after   = 16'($urandom_range(3000));
      regs.recover_cool    = 16'($urandom_range(2000));
      steady_flow = phase == 1;
      drive_traffic(regs, 200, 2 * regs.poll_interval + 4, 0);
    end
    steady_flow = 1'b0;
  endtask

  // The output is held off for a long stretch while words keep coming, so the unit fills
  // up and has to stall its input.
  task automatic test_output_backpressure();
    drive_traffic(DefaultRegs, 150, 15, 200);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_extreme_settings();
    test_idle_release();
    test_random_settings();
    test_output_backpressure();
    settle();
    if (mismatch_count == 0) begin
      $display("touch_poll_backoff_tracker_unit regression: pass");
    end else begin
      $display("touch_poll_backoff_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
